@@ sv/tpe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared types and constants for the timer pool expiry engine.
// ----------------------------------------------------------------------------
package tpe_pkg;

	localparam int POOL   = 64;
	localparam int IDX_W  = (POOL > 1) ? $clog2(POOL) : 1;
	localparam int CNT_W  = $clog2(POOL + 1);
	localparam int ID_W   = 16;
	localparam int CD_W   = 20;
	localparam int TICK_W = 32;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_CANCEL = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	localparam logic [ID_W-1:0] ID_MAX = '1;

	typedef struct packed {
		logic [1:0]      req_type;
		logic [CD_W-1:0] wait_ticks;
		logic [ID_W-1:0] cancel_id;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   ident;
		logic              fired;
		logic              last;
		logic [6:0]        active_count;
		logic [TICK_W-1:0] tick_now;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [CD_W-1:0] cd;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_UP,
		CELL_DOWN
	} cell_cmd_e;

	typedef struct packed {
		cell_cmd_e        cmd;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		entry_t           wr_data;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_PASS,
		S_FIN
	} state_e;

endpackage
`default_nettype wire

@@ sv/tpe_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_cell
// One timer cell of the age-ordered row: holds, takes the newer neighbor's
// entry (insert), or the older neighbor's entry / a written entry (drain).
// ----------------------------------------------------------------------------
module tpe_cell
	import tpe_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_cmd_e cmd,
	input  wire logic      sel,
	input  wire entry_t    up_in,
	input  wire entry_t    dn_in,
	input  wire entry_t    wr_data,
	output entry_t         q
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		case (cmd)
			CELL_UP:   entry_q <= up_in;
			CELL_DOWN: entry_q <= sel ? wr_data : dn_in;
			default:   entry_q <= entry_q;
		endcase
	end

	assign q = entry_q;

endmodule
`default_nettype wire

@@ sv/tpe_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_ctrl
// Request sequencer: drives results, executes add directly, runs cancel and
// tick as a row pass (one entry reaches the head per cycle unless stalled).
// ----------------------------------------------------------------------------
module tpe_ctrl
	import tpe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp,
	input  wire entry_t head,
	output cell_ctl_t cell_ctl
);

	state_e            state_q, state_d;
	req_t              req_q;
	logic [CNT_W-1:0]  live_q;
	logic [CNT_W-1:0]  steps_q;
	logic [ID_W-1:0]   next_id_q;
	logic [TICK_W-1:0] tick_q;
	logic              found_q;
	logic              pend_valid_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [CNT_W-1:0]  pend_cnt_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic              out_free;
	logic              is_tick;
	logic              is_cancel;
	logic              pool_full;
	logic              skip_pass;
	logic              head_due;
	logic              fire;
	logic              step_go;
	logic              emit;
	rsp_t              emit_rsp;
	logic              add_ok;
	logic              tick_adv;

	assign out_free  = !out_valid_q || rsp_ready;
	assign is_tick   = (req_q.req_type == REQ_TICK);
	assign is_cancel = (req_q.req_type == REQ_CANCEL);
	assign pool_full = (live_q == CNT_W'(POOL));
	assign skip_pass = (live_q == '0) || (is_cancel && req_q.cancel_id == '0);
	// only the first (newest) match of a cancel is dropped
	assign head_due  = is_tick ? (head.cd == '0)
	                           : (!found_q && head.id == req_q.cancel_id);
	assign fire      = is_tick && head_due;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (is_tick || is_cancel)
					state_d = skip_pass ? S_FIN : S_PASS;
				else if (out_free)
					state_d = S_IDLE;
			end
			S_PASS: begin
				if (step_go && steps_q == CNT_W'(1))
					state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		cell_ctl         = '0;
		cell_ctl.cmd     = CELL_HOLD;
		cell_ctl.wr_data = head;
		emit             = 1'b0;
		emit_rsp         = '0;
		emit_rsp.tick_now     = tick_q;
		emit_rsp.active_count = 7'(live_q);
		step_go          = 1'b0;
		add_ok           = 1'b0;
		tick_adv         = 1'b0;
		req_ready        = (state_q == S_IDLE);
		case (state_q)
			S_EXEC: begin
				if (!is_tick && !is_cancel && out_free) begin
					emit          = 1'b1;
					emit_rsp.last = 1'b1;
					if (req_q.req_type != REQ_ADD) begin
						emit_rsp.status = ST_MISS;
					end else if (pool_full) begin
						emit_rsp.status = ST_FULL;
					end else begin
						add_ok                = 1'b1;
						emit_rsp.status       = ST_OK;
						emit_rsp.ident        = next_id_q;
						emit_rsp.active_count = 7'(live_q + CNT_W'(1));
						cell_ctl.cmd          = CELL_UP;
						cell_ctl.wr_data.id   = next_id_q;
						cell_ctl.wr_data.cd   = (req_q.wait_ticks == '0) ?
						                        CD_W'(1) : req_q.wait_ticks;
					end
				end
			end
			S_PASS: begin
				// a fire must wait when the held result cannot move out
				step_go = !fire || !pend_valid_q || out_free;
				if (step_go) begin
					cell_ctl.cmd    = CELL_DOWN;
					cell_ctl.wr_en  = !head_due;
					cell_ctl.wr_idx = IDX_W'(live_q - CNT_W'(1));
					if (is_tick)
						cell_ctl.wr_data.cd = head.cd - CD_W'(1);
					if (fire && pend_valid_q) begin
						emit                  = 1'b1;
						emit_rsp.status       = ST_OK;
						emit_rsp.ident        = pend_id_q;
						emit_rsp.fired        = 1'b1;
						emit_rsp.active_count = 7'(pend_cnt_q);
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					emit          = 1'b1;
					emit_rsp.last = 1'b1;
					if (is_tick) begin
						tick_adv = 1'b1;
						if (pend_valid_q) begin
							emit_rsp.ident        = pend_id_q;
							emit_rsp.fired        = 1'b1;
							emit_rsp.active_count = 7'(pend_cnt_q);
						end
					end else begin
						emit_rsp.status = found_q ? ST_OK : ST_MISS;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			live_q       <= '0;
			steps_q      <= '0;
			next_id_q    <= ID_W'(1);
			tick_q       <= '0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req_valid) begin
				steps_q      <= live_q;
				found_q      <= 1'b0;
				pend_valid_q <= 1'b0;
			end
			if (add_ok) begin
				live_q    <= live_q + CNT_W'(1);
				next_id_q <= (next_id_q == ID_MAX) ? ID_W'(1) : next_id_q + ID_W'(1);
			end
			if (step_go) begin
				steps_q <= steps_q - CNT_W'(1);
				if (head_due) begin
					live_q <= live_q - CNT_W'(1);
					if (is_cancel)
						found_q <= 1'b1;
				end
				if (fire)
					pend_valid_q <= 1'b1;
			end
			if (tick_adv)
				tick_q <= tick_q + TICK_W'(1);
			if (emit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid)
			req_q <= req;
		if (step_go && fire) begin
			pend_id_q  <= head.id;
			pend_cnt_q <= live_q - CNT_W'(1);
		end
		if (emit)
			out_q <= emit_rsp;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

@@ sv/timer_pool_expiry_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// timer_pool_expiry_engine
// Pool of one-shot timers kept in a row of cells ordered newest to oldest.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req): add a timer, cancel by id, or
//   advance one tick. One request is in work at a time; req_ready is high
//   only while no request is in work, and a request is taken even while the
//   previous result still waits on the rsp channel.
//   rsp channel (rsp_valid/rsp_ready/rsp): one result per add and cancel,
//   one or more per tick (one per expired timer, newest first); the final
//   result of a request carries last.
//   Add and unknown codes are answered from the EXEC state. Cancel and tick
//   walk the live timers through the head of the cell row, one entry per
//   cycle unless an expiry waits; the final result comes from the FIN state
//   (no pass with an empty pool), and the next request is taken after it.
//   A stalled rsp channel holds the output register; a tick pass pauses on
//   an expiry until the held result can move out. Reset empties the pool,
//   sets the tick counter to 0 and the next id to 1; no clearing pass.
// ----------------------------------------------------------------------------
module timer_pool_expiry_engine
	import tpe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	cell_ctl_t cell_ctl;
	entry_t    cell_q [POOL];

	tpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.head      (cell_q[0]),
		.cell_ctl  (cell_ctl)
	);

	for (genvar j = 0; j < POOL; j++) begin : g_cell
		entry_t up_in;
		entry_t dn_in;
		logic   sel;

		if (j == 0) begin : g_first
			assign up_in = cell_ctl.wr_data;
		end else begin : g_up
			assign up_in = cell_q[j-1];
		end
		if (j == POOL - 1) begin : g_last
			assign dn_in = cell_ctl.wr_data;
		end else begin : g_dn
			assign dn_in = cell_q[j+1];
		end
		assign sel = cell_ctl.wr_en && (cell_ctl.wr_idx == IDX_W'(j));

		tpe_cell u_cell (
			.clk     (clk),
			.cmd     (cell_ctl.cmd),
			.sel     (sel),
			.up_in   (up_in),
			.dn_in   (dn_in),
			.wr_data (cell_ctl.wr_data),
			.q       (cell_q[j])
		);
	end

	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fired |-> rsp.status == ST_OK && rsp.ident != '0)
		else $error("fired result without ok status or id");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while one is in work");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.active_count <= 7'(POOL))
		else $error("active count beyond pool size");

	a_multi_fired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> rsp.fired)
		else $error("non-final result that is not an expiry");

endmodule
`default_nettype wire

@@ test/tb_timer_pool_expiry_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_pool_expiry_engine
// Self-checking bench for the timer pool: adds, cancels, ticks and the unused
// request code go in over valid/ready. A scoreboard class keeps its own copy
// of the pool and predicts every result of each request. Both channels idle
// and stall at random. Halfway through the pool is filled with equal waits
// so that one tick fires a long burst.
// ----------------------------------------------------------------------------
module tb_timer_pool_expiry_engine;
	import tpe_pkg::*;

	localparam logic [1:0]      REQ_UNUSED   = 2'd3;
	localparam logic [CD_W-1:0] CD_MAX       = '1;
	localparam int              CLK_HALF     = 5;
	localparam int              RANDOM_ITEMS = 200;
	localparam int              STALL_LIMIT  = 2000;
	localparam int              DRAIN_CYCLES = POOL + 16;

	class expiry_scoreboard;
		bit                slot_on[POOL];
		logic [ID_W-1:0]   slot_id[POOL];
		logic [CD_W-1:0]   slot_left[POOL];
		int                slot_rank[POOL];
		int                live;
		logic [ID_W-1:0]   next_id;
		logic [TICK_W-1:0] tick_ctr;
		rsp_t              pending[$];
		int                mismatches;
		int                checked;
		int                fired_total;
		int                full_total;
		int                miss_total;
		int                peak_burst;

		function new();
			foreach (slot_on[i]) slot_on[i] = 1'b0;
			live        = 0;
			next_id     = ID_W'(1);
			tick_ctr    = '0;
			mismatches  = 0;
			checked     = 0;
			fired_total = 0;
			full_total  = 0;
			miss_total  = 0;
			peak_burst  = 0;
		endfunction

		function void expect_result(logic [1:0] status, logic [ID_W-1:0] id, logic fired);
			rsp_t r;
			r.status       = status;
			r.ident        = id;
			r.fired        = fired;
			r.last         = 1'b0;
			r.active_count = 7'(live);
			r.tick_now     = tick_ctr;
			pending.push_back(r);
		endfunction

		// ranks above the freed one close the gap, so ranks stay 0..live-1
		function void release_slot(int s);
			slot_on[s] = 1'b0;
			for (int j = 0; j < POOL; j++)
				if (slot_on[j] && slot_rank[j] > slot_rank[s])
					slot_rank[j]--;
			live--;
		endfunction

		function void note_request(req_t r);
			rsp_t            tail;
			bit              due[POOL];
			logic [CD_W-1:0] w;
			logic [ID_W-1:0] gone;
			int              s;
			int              k;
			int              burst;
			case (r.req_type)
			REQ_ADD: begin
				s = -1;
				for (int i = 0; i < POOL; i++)
					if (!slot_on[i] && s < 0)
						s = i;
				if (live >= POOL || s < 0) begin
					full_total++;
					expect_result(ST_FULL, '0, 1'b0);
				end else begin
					w = (r.wait_ticks == '0) ? CD_W'(1) : r.wait_ticks;
					slot_on[s]   = 1'b1;
					slot_id[s]   = next_id;
					slot_left[s] = w;
					slot_rank[s] = live;
					live++;
					expect_result(ST_OK, next_id, 1'b0);
					next_id = (next_id == ID_MAX) ? ID_W'(1) : next_id + 1'b1;
				end
			end
			REQ_CANCEL: begin
				s = -1;
				if (r.cancel_id != '0)
					for (int i = 0; i < POOL; i++)
						if (slot_on[i] && slot_id[i] == r.cancel_id &&
						    (s < 0 || slot_rank[i] > slot_rank[s]))
							s = i;
				if (s >= 0) begin
					release_slot(s);
					expect_result(ST_OK, '0, 1'b0);
				end else begin
					miss_total++;
					expect_result(ST_MISS, '0, 1'b0);
				end
			end
			REQ_TICK: begin
				for (int i = 0; i < POOL; i++) begin
					due[i] = 1'b0;
					if (slot_on[i]) begin
						if (slot_left[i] == '0)
							due[i] = 1'b1;
						else
							slot_left[i]--;
					end
				end
				burst = 0;
				// walk from the newest rank down; drops only shift ranks above
				for (k = live; k > 0; k--) begin
					s = -1;
					for (int i = 0; i < POOL; i++)
						if (slot_on[i] && slot_rank[i] == k - 1)
							s = i;
					if (s >= 0 && due[s]) begin
						gone = slot_id[s];
						release_slot(s);
						expect_result(ST_OK, gone, 1'b1);
						burst++;
					end
				end
				if (burst == 0)
					expect_result(ST_OK, '0, 1'b0);
				fired_total += burst;
				if (burst > peak_burst)
					peak_burst = burst;
				tick_ctr++;
			end
			default: begin
				miss_total++;
				expect_result(ST_MISS, '0, 1'b0);
			end
			endcase
			tail = pending.pop_back();
			tail.last = 1'b1;
			pending.push_back(tail);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result st=%0d id=%0d fired=%0b last=%0b",
						$time, got.status, got.ident, got.fired, got.last);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.status !== want.status || got.ident !== want.ident ||
			    got.fired !== want.fired || got.last !== want.last ||
			    got.active_count !== want.active_count || got.tick_now !== want.tick_now) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result mismatch", $time);
					$display("  expected st=%0d id=%0d fired=%0b last=%0b active=%0d tick=%0d",
						want.status, want.ident, want.fired, want.last,
						want.active_count, want.tick_now);
					$display("  actual   st=%0d id=%0d fired=%0b last=%0b active=%0d tick=%0d",
						got.status, got.ident, got.fired, got.last,
						got.active_count, got.tick_now);
				end
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b1;
	rsp_t rsp;

	bit   idle_on       = 1'b1;
	int   rsp_hold      = 0;
	int   quiet_cycles  = 0;
	int   requests_sent = 0;

	expiry_scoreboard sb = new();

	timer_pool_expiry_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #CLK_HALF clk = ~clk;

	// result side: check each transfer, then at random hold ready low
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				sb.check_result(rsp);
				rsp_hold = idle_on ? $urandom_range(0, 7) : 0;
				if (rsp_hold != 0)
					rsp_ready <= 1'b0;
			end else if (rsp_hold != 0) begin
				rsp_hold--;
				if (rsp_hold == 0)
					rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					quiet_cycles, sb.pending.size());
				$display("** timer_pool_expiry_engine: FAILED **");
				$finish;
			end
		end
	end

	// valid stays up across back-to-back requests; it only drops for a gap
	task automatic issue(input logic [1:0] kind, input logic [CD_W-1:0] w,
	                     input logic [ID_W-1:0] cid);
		req_t r;
		int   gap;
		r.req_type   = kind;
		r.wait_ticks = w;
		r.cancel_id  = cid;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(r);
		requests_sent++;
	endtask

	task automatic add_timer(input logic [CD_W-1:0] w);
		issue(REQ_ADD, w, ID_W'($urandom()));
	endtask

	task automatic cancel_timer(input logic [ID_W-1:0] id);
		issue(REQ_CANCEL, CD_W'($urandom()), id);
	endtask

	task automatic tick_timers();
		issue(REQ_TICK, CD_W'($urandom()), ID_W'($urandom()));
	endtask

	function automatic logic [CD_W-1:0] draw_wait();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll < 13)
			return CD_W'($urandom_range(1, 12));
		if (roll < 18)
			return CD_W'($urandom_range(13, 80));
		return CD_W'($urandom());
	endfunction

	initial begin
		logic [ID_W-1:0] live_ids[$];
		int              pick;
		int              how;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pool, bad codes and ids, zero and extreme waits
		tick_timers();
		cancel_timer(ID_W'(5));
		issue(REQ_UNUSED, CD_MAX, ID_MAX);
		add_timer('0);
		add_timer(CD_MAX);
		add_timer(CD_W'(1));
		add_timer(CD_W'(2));
		add_timer(CD_W'(1));
		cancel_timer('0);
		cancel_timer(ID_MAX);
		cancel_timer(ID_W'(4));
		tick_timers();
		tick_timers();
		tick_timers();
		add_timer(CD_W'(3));
		add_timer(CD_W'(3));
		repeat (4) tick_timers();
		add_timer(CD_W'(20'h80000));

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (k == RANDOM_ITEMS / 2) begin
				// fill the pool with equal waits so one tick fires a long burst
				while (sb.live < POOL)
					add_timer(CD_W'(4));
				repeat (3) add_timer(draw_wait());
			end
			pick = $urandom_range(0, 99);
			how  = $urandom_range(0, 9);
			if (pick < 40) begin
				add_timer(draw_wait());
			end else if (pick < 65) begin
				live_ids.delete();
				for (int i = 0; i < POOL; i++)
					if (sb.slot_on[i])
						live_ids.push_back(sb.slot_id[i]);
				if (how < 7 && live_ids.size() != 0)
					cancel_timer(live_ids[$urandom_range(0, live_ids.size() - 1)]);
				else if (how < 8)
					cancel_timer('0);
				else
					cancel_timer(ID_W'($urandom()));
			end else if (pick < 95) begin
				tick_timers();
			end else begin
				issue(REQ_UNUSED, CD_W'($urandom()), ID_W'($urandom()));
			end
		end

		req_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results checked; %0d timers fired (largest tick %0d),",
			requests_sent, sb.checked, sb.fired_total, sb.peak_burst);
		$display("%0d adds refused on a full pool, %0d cancel or unused-code misses",
			sb.full_total, sb.miss_total);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("** timer_pool_expiry_engine: PASSED **");
		else
			$display("** timer_pool_expiry_engine: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
sv/tpe_pkg.sv
sv/tpe_cell.sv
sv/tpe_ctrl.sv
sv/timer_pool_expiry_engine.sv
test/tb_timer_pool_expiry_engine.sv
